// ----- rtl/usbsx_pkg.sv -----
// usbsx_pkg: shared types and constants of the USB-MIDI sysex reassembler.
// Used by the front classifier, the command queue and the back executor.
`timescale 1ns / 1ps
`default_nettype none

package usbsx_pkg;

  localparam logic [3:0] CIN_MISC     = 4'd0;
  localparam logic [3:0] CIN_SX_START = 4'd4;
  localparam logic [3:0] CIN_SX_END1  = 4'd5;
  localparam logic [3:0] CIN_SX_END2  = 4'd6;
  localparam logic [3:0] CIN_SX_END3  = 4'd7;

  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSEX_END      = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;

  // One command from the front to the back.
  // plain: emit data[0..n-1] as a message. Otherwise store data[0..n-1]
  // into the payload, then emit the sysex run if run is set.
  typedef struct packed {
    logic            plain;
    logic            clear;
    logic            run;
    logic [1:0]      n;
    logic [2:0][7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/usb_midi_sysex_reassembler.sv -----
// usb_midi_sysex_reassembler: top level of the USB-MIDI sysex reassembler.
// Instantiates usbsx_front, usbsx_queue and usbsx_back; uses usbsx_pkg.
//
// Input channel (in_valid/in_stall): one USB-MIDI event packet per item,
// code index number plus three bytes. Output channel (out_valid/out_stall):
// one MIDI byte per item with a last-byte mark and a truncated flag.
// Plain messages come out as one to three bytes; a closing sysex packet
// produces F0, the stored payload (up to MAX_PAYLOAD bytes) and F7.
// The front classifies a packet in the cycle it is accepted and pushes a
// command into a four-entry queue; in_stall is high only while that queue
// is full. The back takes one command at a time: it fetches the command,
// emits each plain byte, or stores each payload byte and then finishes,
// and for a run emits F0, reads each payload byte from memory and emits
// it, and then emits F7.
// A plain message's first byte passes through the queue, the back's command
// register and the output register; a run's F0 also waits on the stored bytes.
// A stall on the output holds the registered result; the back halts at
// its next output byte and the front keeps accepting until the queue fills.
// Reset (rst_n low, synchronous) closes any open sysex, empties the queue
// and drops the stored payload; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module usb_midi_sysex_reassembler
  import usbsx_pkg::*;
#(
  parameter int MAX_PAYLOAD = 62
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_cin,
  input  wire logic [7:0] in_byte0,
  input  wire logic [7:0] in_byte1,
  input  wire logic [7:0] in_byte2,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_byte,
  output logic            out_truncated
);

  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_empty;

  usbsx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cin   (in_cin),
    .in_byte0 (in_byte0),
    .in_byte1 (in_byte1),
    .in_byte2 (in_byte2),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  usbsx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  usbsx_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_truncated (out_truncated)
  );

endmodule

`default_nettype wire

// ----- rtl/usbsx_front.sv -----
// usbsx_front: accepts packets, tracks the open-sysex flag and turns each
// packet into a command for the back part. Depends on usbsx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbsx_front
  import usbsx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_cin,
  input  wire logic [7:0] in_byte0,
  input  wire logic [7:0] in_byte1,
  input  wire logic [7:0] in_byte2,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic active_r, active_nxt;
  logic has_cmd;
  logic start, end2, end3;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign start    = (in_byte0 == SYSEX_START);
  assign end2     = (in_byte1 == SYSEX_END);
  assign end3     = (in_byte2 == SYSEX_END);

  always_comb begin
    q_cmd      = '0;
    has_cmd    = 1'b0;
    active_nxt = active_r;
    unique case (in_cin)
      CIN_MISC: begin
        if (in_byte0 < REALTIME_FIRST && !active_r) begin
          has_cmd     = 1'b1;
          q_cmd.plain = 1'b1;
          q_cmd.clear = 1'b1;
          q_cmd.n     = 2'd3;
          q_cmd.data  = {in_byte2, in_byte1, in_byte0};
        end
      end
      CIN_SX_START: begin
        has_cmd = 1'b1;
        if (start) begin
          active_nxt  = 1'b1;
          q_cmd.clear = 1'b1;
          q_cmd.n     = 2'd2;
          q_cmd.data  = {8'h00, in_byte2, in_byte1};
        end else begin
          q_cmd.plain = !active_r;
          q_cmd.n     = 2'd3;
          q_cmd.data  = {in_byte2, in_byte1, in_byte0};
        end
      end
      CIN_SX_END1: begin
        has_cmd = 1'b1;
        q_cmd.data = {8'h00, 8'h00, in_byte0};
        if (in_byte0 == SYSEX_END && active_r) begin
          active_nxt = 1'b0;
          q_cmd.run  = 1'b1;
          q_cmd.n    = 2'd0;
        end else begin
          q_cmd.plain = !active_r;
          q_cmd.n     = 2'd1;
        end
      end
      CIN_SX_END2: begin
        has_cmd = 1'b1;
        if (start && end2) begin
          active_nxt  = 1'b0;
          q_cmd.clear = 1'b1;
          q_cmd.run   = 1'b1;
          q_cmd.n     = 2'd0;
        end else if (start) begin
          active_nxt  = 1'b1;
          q_cmd.clear = 1'b1;
          q_cmd.n     = 2'd1;
          q_cmd.data  = {8'h00, 8'h00, in_byte1};
        end else if (end2) begin
          // closes an open run, or emits F0 byte0 F7 when none is open
          active_nxt = 1'b0;
          q_cmd.run  = 1'b1;
          q_cmd.n    = 2'd1;
          q_cmd.data = {8'h00, 8'h00, in_byte0};
        end else begin
          q_cmd.plain = !active_r;
          q_cmd.n     = 2'd2;
          q_cmd.data  = {8'h00, in_byte1, in_byte0};
        end
      end
      CIN_SX_END3: begin
        has_cmd = 1'b1;
        if (start && end3) begin
          q_cmd.plain = 1'b1;
          q_cmd.n     = 2'd3;
          q_cmd.data  = {in_byte2, in_byte1, in_byte0};
        end else if (start) begin
          active_nxt  = 1'b1;
          q_cmd.clear = 1'b1;
          q_cmd.n     = 2'd2;
          q_cmd.data  = {8'h00, in_byte2, in_byte1};
        end else if (active_r && end3) begin
          active_nxt = 1'b0;
          q_cmd.run  = 1'b1;
          q_cmd.n    = 2'd2;
          q_cmd.data = {8'h00, in_byte1, in_byte0};
        end else begin
          q_cmd.plain = !active_r;
          q_cmd.n     = 2'd3;
          q_cmd.data  = {in_byte2, in_byte1, in_byte0};
        end
      end
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

  assign q_push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (accept) begin
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/usbsx_queue.sv -----
// usbsx_queue: short command queue between front and back.
// Depends on usbsx_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module usbsx_queue
  import usbsx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      full,
  output logic      empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      cnt_r;

  assign full     = (cnt_r == (PW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(DEPTH)) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/usbsx_back.sv -----
// usbsx_back: executes queued commands, keeps the payload memory, count and
// overflow flag, and drives the registered result channel. Uses usbsx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbsx_back
  import usbsx_pkg::*;
#(
  parameter int MAX_PAYLOAD = 62
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t head_cmd,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  output logic       out_truncated
);

  localparam int AW    = $clog2(MAX_PAYLOAD);
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STORE = 3'd1;
  localparam logic [2:0] S_PLAIN = 3'd2;
  localparam logic [2:0] S_F0    = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LD    = 3'd5;
  localparam logic [2:0] S_F7    = 3'd6;

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rd_data_r;

  logic [2:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r, out_trunc_r;

  logic             can_load, load;
  logic [7:0]       load_byte;
  logic             load_last, load_trunc;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             has_room;

  assign can_load = !out_valid_r || !out_stall;
  assign has_room = (count_r < CNT_W'(MAX_PAYLOAD));

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    q_pop      = 1'b0;
    load       = 1'b0;
    load_byte  = 8'h00;
    load_last  = 1'b0;
    load_trunc = 1'b0;
    wr_en      = 1'b0;
    wr_data    = cmd_r.data[0];
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = head_cmd;
          idx_nxt = 2'd0;
          if (head_cmd.clear) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = head_cmd.plain ? S_PLAIN : S_STORE;
        end
      end
      S_STORE: begin
        if (idx_r < cmd_r.n) begin
          wr_data = cmd_r.data[idx_r];
          if (has_room) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          idx_nxt = idx_r + 2'd1;
        end else begin
          state_nxt = cmd_r.run ? S_F0 : S_IDLE;
        end
      end
      S_PLAIN: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = cmd_r.data[idx_r];
          load_last = (idx_r == cmd_r.n - 2'd1);
          idx_nxt   = idx_r + 2'd1;
          if (load_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_F0: begin
        if (can_load) begin
          load       = 1'b1;
          load_byte  = SYSEX_START;
          load_trunc = ovf_r;
          rd_idx_nxt = '0;
          state_nxt  = (count_r == '0) ? S_F7 : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        if (can_load) begin
          load       = 1'b1;
          load_byte  = rd_data_r;
          load_trunc = ovf_r;
          rd_idx_nxt = rd_idx_r + AW'(1);
          state_nxt  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r) ? S_F7 : S_RD;
        end
      end
      S_F7: begin
        if (can_load) begin
          load       = 1'b1;
          load_byte  = SYSEX_END;
          load_last  = 1'b1;
          load_trunc = ovf_r;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (load) begin
      out_byte_r  <= load_byte;
      out_last_r  <= load_last;
      out_trunc_r <= load_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;
  assign out_truncated = out_trunc_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAYLOAD)) else $error("payload count beyond store");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(MAX_PAYLOAD)) else $error("overflow without full store");
  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_trunc_r && out_last_r) |-> out_byte_r == SYSEX_END)
    else $error("truncated run not closed by F7");
`endif

endmodule

`default_nettype wire
